/* rtl/drrip_streaming_deadblock_replacement_macros.svh */
// Assertion macros for the DRRIP streaming dead-block replacement block.
// Included by the top level; depends on nothing else.
`ifndef DRRIP_STREAMING_DEADBLOCK_REPLACEMENT_MACROS_SVH
`define DRRIP_STREAMING_DEADBLOCK_REPLACEMENT_MACROS_SVH
// Asserts that a condition implies another on the same edge.
`define DRSD_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Asserts that a condition implies another on the next edge.
`define DRSD_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/drsd_pkg.sv */
// Shared types and constants for the DRRIP streaming dead-block replacement block.
// No dependencies.
package drsd_pkg;
  localparam int NUM_SETS_D      = 2048;
  localparam int NUM_WAYS_D      = 16;
  localparam int LEADER_SETS_D   = 64;
  localparam int SELECTOR_BITS_D = 10;
  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd2;
  localparam logic [7:0] PERIOD_RESET = 8'd32;

  typedef enum logic {OP_VICTIM = 1'b0, OP_UPDATE = 1'b1} op_t;

  typedef struct packed {
    logic        opcode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [31:0] block_address;
    logic        hit;
  } in_item_t;

  typedef struct packed {
    logic [4:0] vic_way;
    logic       is_bypass;
  } out_item_t;

  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_WORK, BK_CLEAR} bk_state_t;
endpackage

/* rtl/drsd_front.sv */
// Front end: accepts transfers, reduces set and way, and queues them (two entries).
// Depends on drsd_pkg.
module drsd_front #(
  parameter int NUM_SETS = drsd_pkg::NUM_SETS_D,
  parameter int NUM_WAYS = drsd_pkg::NUM_WAYS_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  drsd_pkg::in_item_t    in_data,
  output logic                  q_valid,
  input  logic                  q_take,
  output logic                  q_op,
  output logic [$clog2(NUM_SETS)-1:0] q_set,
  output logic [$clog2(NUM_WAYS)-1:0] q_way,
  output logic [31:0]           q_blk,
  output logic                  q_hit
);
  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = $clog2(NUM_WAYS);
  localparam int EW = 1 + SW + WW + 32 + 1;

  logic [EW-1:0] ent_r [2];
  logic [EW-1:0] ent_nxt;
  logic          rd_r, wr_r;
  logic [1:0]    cnt_r;
  logic          push, pop;
  logic [10:0]   s_full;
  logic [3:0]    w_full;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop  = q_valid && q_take;
  assign q_valid = (cnt_r != 2'd0);

  // The geometry is a power of two, so reducing set and way keeps the low bits.
  always_comb begin
    s_full = in_data.set_index;
    w_full = in_data.way;
    ent_nxt = {in_data.opcode, s_full[SW-1:0], w_full[WW-1:0],
               in_data.block_address, in_data.hit};
  end

  assign {q_op, q_set, q_way, q_blk, q_hit} = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_r] <= ent_nxt;
        wr_r <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/drsd_back.sv */
// Back end: per-set row memory, read-modify-write of one set per transfer.
// Depends on drsd_pkg.
module drsd_back #(
  parameter int NUM_SETS      = drsd_pkg::NUM_SETS_D,
  parameter int NUM_WAYS      = drsd_pkg::NUM_WAYS_D,
  parameter int LEADER_SETS   = drsd_pkg::LEADER_SETS_D,
  parameter int SELECTOR_BITS = drsd_pkg::SELECTOR_BITS_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  logic                  q_valid,
  output logic                  q_take,
  input  logic                  q_op,
  input  logic [$clog2(NUM_SETS)-1:0] q_set,
  input  logic [$clog2(NUM_WAYS)-1:0] q_way,
  input  logic [31:0]           q_blk,
  input  logic                  q_hit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output drsd_pkg::out_item_t   out_data,
  output logic                  busy
);
  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = $clog2(NUM_WAYS);
  localparam int RW = NUM_WAYS * 5;          // rrpv, dead flag, dead count per way
  localparam int SX = SELECTOR_BITS;
  localparam logic [SX-1:0] SEL_MID = SX'(1) << (SX - 1);
  localparam logic [SX-1:0] SEL_MAX = '1;

  // Row layout per way: [4:3] rrpv, [2] dead flag, [1:0] dead count.
  logic [RW-1:0] row_mem [NUM_SETS];
  logic [32:0]   set_mem [NUM_SETS];       // {streaming mark, previous block}
  logic [RW-1:0] row_q_r;
  logic [32:0]   set_q_r;

  drsd_pkg::bk_state_t st_r, st_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic          op_r, hit_r;
  logic [SW-1:0] set_r;
  logic [WW-1:0] way_r;
  logic [31:0]   blk_r;
  logic [SX-1:0] psel_r, psel_nxt;
  logic [7:0]    bcnt_r, bcnt_nxt, period_r;
  logic          ov_r, ov_nxt;
  drsd_pkg::out_item_t od_r, od_nxt;
  logic          row_we, set_we;
  logic [SW-1:0] wa;
  logic [RW-1:0] row_wd;
  logic [32:0]   set_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= drsd_pkg::PERIOD_RESET;
    else if (cfg_we) period_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[wa] <= row_wd;
    if (set_we) set_mem[wa] <= set_wd;
    row_q_r <= row_mem[q_set];
    set_q_r <= set_mem[q_set];
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy = (st_r != drsd_pkg::BK_IDLE);

  always_comb begin
    logic [1:0] top, add, ins, rv, dc;
    logic       df, strm, lsr, lbr, brrip;
    logic [31:0] delta;
    logic [4:0]  vic;
    logic        found;
    st_nxt = st_r; clr_nxt = clr_r; psel_nxt = psel_r; bcnt_nxt = bcnt_r;
    ov_nxt = ov_r && out_stall; od_nxt = od_r;
    q_take = 1'b0; row_we = 1'b0; set_we = 1'b0; wa = set_r;
    row_wd = row_q_r; set_wd = set_q_r;
    top = 2'd0; add = 2'd0; ins = drsd_pkg::RRPV_NEAR; vic = 5'd0; found = 1'b0;
    rv = 2'd0; dc = 2'd0; df = 1'b0; strm = 1'b0; brrip = 1'b0;
    delta = q_blk - q_blk;
    lsr = (32'(set_r) < 32'(LEADER_SETS));
    lbr = (33'(set_r) + 33'(LEADER_SETS) >= 33'(NUM_SETS));
    unique case (st_r)
      drsd_pkg::BK_CLEAR: begin
        row_we = 1'b1; set_we = 1'b1; wa = clr_r;
        for (int w = 0; w < NUM_WAYS; w++) row_wd[w*5 +: 5] = {drsd_pkg::RRPV_MAX, 3'b000};
        set_wd = '0;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(NUM_SETS - 1)) st_nxt = drsd_pkg::BK_IDLE;
      end
      drsd_pkg::BK_IDLE: begin
        if (q_valid && !ov_nxt) begin
          q_take = 1'b1;
          st_nxt = drsd_pkg::BK_WORK;
        end
      end
      drsd_pkg::BK_READ: st_nxt = drsd_pkg::BK_WORK;
      drsd_pkg::BK_WORK: begin
        st_nxt = drsd_pkg::BK_IDLE;
        ov_nxt = 1'b1;
        if (op_r == drsd_pkg::OP_VICTIM) begin
          if (set_q_r[32]) begin
            od_nxt.vic_way = 5'(NUM_WAYS);
            od_nxt.is_bypass = 1'b1;
          end else begin
            for (int w = 0; w < NUM_WAYS; w++)
              if (row_q_r[w*5+3 +: 2] > top) top = row_q_r[w*5+3 +: 2];
            add = drsd_pkg::RRPV_MAX - top;
            for (int w = 0; w < NUM_WAYS; w++) begin
              row_wd[w*5+3 +: 2] = row_q_r[w*5+3 +: 2] + add;
              if (!found && row_wd[w*5+3 +: 2] == drsd_pkg::RRPV_MAX) begin
                found = 1'b1; vic = 5'(w);
              end
            end
            row_we = 1'b1;
            od_nxt.vic_way = vic;
            od_nxt.is_bypass = 1'b0;
          end
        end else begin
          strm = set_q_r[32];
          delta = blk_r - set_q_r[31:0];
          if (set_q_r[31:0] != 32'd0 && (delta == 32'd1 || delta == '1)) strm = 1'b1;
          else if (set_q_r[31:0] != 32'd0 && delta != 32'd0) strm = 1'b0;
          set_we = 1'b1;
          set_wd = {strm, blk_r};
          od_nxt.vic_way = 5'd0;
          od_nxt.is_bypass = strm && !hit_r;
          if (!(strm && !hit_r)) begin
            rv = row_q_r[way_r*5+3 +: 2];
            df = row_q_r[way_r*5+2];
            dc = row_q_r[way_r*5 +: 2];
            if (hit_r) begin
              rv = 2'd0; df = 1'b0;
              if (dc != 2'd0) dc = dc - 2'd1;
              if (lsr) begin
                if (psel_r != SEL_MAX) psel_nxt = psel_r + SX'(1);
              end else if (lbr) begin
                if (psel_r != '0) psel_nxt = psel_r - SX'(1);
              end
            end else begin
              brrip = !lsr && (lbr || psel_r < SEL_MID);
              if (brrip) begin
                if (9'(bcnt_r) + 9'd1 >= 9'(period_r)) begin
                  bcnt_nxt = 8'd0; ins = drsd_pkg::RRPV_NEAR;
                end else begin
                  bcnt_nxt = bcnt_r + 8'd1; ins = drsd_pkg::RRPV_MAX;
                end
              end
              if (dc >= 2'd2) ins = drsd_pkg::RRPV_MAX;
              rv = ins;
              if (ins == drsd_pkg::RRPV_MAX && !df) begin
                df = 1'b1;
                if (dc != 2'd3) dc = dc + 2'd1;
              end
            end
            row_wd[way_r*5 +: 5] = {rv, df, dc};
            row_we = 1'b1;
          end
        end
      end
      default: st_nxt = drsd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      op_r <= q_op; set_r <= q_set; way_r <= q_way; blk_r <= q_blk; hit_r <= q_hit;
    end
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= drsd_pkg::BK_CLEAR;
      clr_r <= '0;
      psel_r <= SEL_MID;
      bcnt_r <= 8'd0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      psel_r <= psel_nxt;
      bcnt_r <= bcnt_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

/* rtl/drrip_streaming_deadblock_replacement.sv */
// Channel   | Direction | Handshake
// in_*      | input     | in_valid / in_stall, payload in_data
// out_*     | output    | out_valid / out_stall, payload out_data
// cfg_*     | input     | cfg_we / cfg_data, bimodal period
// In the back end each item takes a registered read of the set row, then
// modify and write back; no new item is taken until the write back is done.
// After reset a clearing pass over all NUM_SETS sets initialises the memories;
// items queue at the front (two entries) but are not processed until it ends.
// A stalled result holds the back end; the front keeps taking transfers until full.
// Top level; depends on drsd_pkg, drsd_front, drsd_back and the macros header.
`include "drrip_streaming_deadblock_replacement_macros.svh"
module drrip_streaming_deadblock_replacement #(
  parameter int NUM_SETS      = drsd_pkg::NUM_SETS_D,
  parameter int NUM_WAYS      = drsd_pkg::NUM_WAYS_D,
  parameter int LEADER_SETS   = drsd_pkg::LEADER_SETS_D,
  parameter int SELECTOR_BITS = drsd_pkg::SELECTOR_BITS_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  drsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output drsd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);
  logic q_valid, q_take, q_op, q_hit, busy;
  logic [$clog2(NUM_SETS)-1:0] q_set;
  logic [$clog2(NUM_WAYS)-1:0] q_way;
  logic [31:0] q_blk;
  logic byp_nz;

  drsd_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_op, .q_set, .q_way, .q_blk, .q_hit
  );

  drsd_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
              .LEADER_SETS(LEADER_SETS), .SELECTOR_BITS(SELECTOR_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data, .q_valid, .q_take, .q_op, .q_set, .q_way,
    .q_blk, .q_hit, .out_valid, .out_stall, .out_data, .busy
  );

  assign byp_nz = out_valid && out_data.is_bypass && (out_data.vic_way != 5'd0);

  `DRSD_ASSERT_IMP(a_take_needs_valid, clk, rst_n, q_take, q_valid)
  `DRSD_ASSERT_NXT(a_take_makes_busy, clk, rst_n, q_take, busy)
  `DRSD_ASSERT_IMP(a_bypass_code, clk, rst_n, byp_nz, out_data.vic_way == 5'(NUM_WAYS))
endmodule
